// ----- rtl/core/psg_pkg.sv -----
package psg_pkg;

   localparam int NUM_SENS   = 9;
   localparam int CFG_DIST_W = 10;
   localparam int SCALE_W    = 9;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int LEVEL_W    = 2;

   localparam logic [LEVEL_W-1:0] LVL_OK     = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_DANGER = 2'd2;

   localparam logic [1:0] ACT_OK     = 2'd0;
   localparam logic [1:0] ACT_WARN   = 2'd1;
   localparam logic [1:0] ACT_DANGER = 2'd2;
   localparam logic [1:0] ACT_HOLD   = 2'd3;

   localparam logic [SCALE_W-1:0] SCALE_ONE       = 9'd256;
   localparam logic [SCALE_W-1:0] SCALE_HALF      = 9'd128;
   localparam logic [SCALE_W-1:0] SCALE_FLOOR_MIN = 9'd13;

   localparam logic [2:0] REG_ENABLE   = 3'd0;
   localparam logic [2:0] REG_WARN     = 3'd1;
   localparam logic [2:0] REG_DANGER   = 3'd2;
   localparam logic [2:0] REG_MIN_SCL  = 3'd3;
   localparam logic [2:0] REG_SILENCE  = 3'd4;
   localparam logic [2:0] REG_DISABLED = 3'd5;

   // per-sensor stop distances, in port order rear l/c/r, front r/c/l, head l/r/c
   localparam logic [4:0] SENSOR_THD [NUM_SENS] =
      '{5'd20, 5'd15, 5'd20, 5'd15, 5'd10, 5'd15, 5'd20, 5'd20, 5'd20};
   localparam logic [3:0] FRONT_SEL [3] = '{4'd5, 4'd4, 4'd3};
   localparam logic [3:0] REAR_SEL  [3] = '{4'd0, 4'd1, 4'd2};

   typedef struct packed {
      logic [1:0]            act;
      logic                  need_div;
      logic [SCALE_W-1:0]    raw_scale;
      logic [CFG_DIST_W-1:0] diff;
      logic [CFG_DIST_W-1:0] den;
   } psg_cmd_type;

endpackage

// ----- rtl/core/psg_front.sv -----
module psg_front #(
   parameter int DIST_BITS = 10
) (
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [DIST_BITS-1:0]             sens_dist [psg_pkg::NUM_SENS],
   input  logic                             enable,
   input  logic [psg_pkg::CFG_DIST_W-1:0]   warn_thd,
   input  logic [psg_pkg::CFG_DIST_W-1:0]   danger_thd,
   input  logic [psg_pkg::CFG_DIST_W-1:0]   silence_code,
   input  logic [psg_pkg::CFG_DIST_W-1:0]   disabled_code,
   input  logic                             q_full,
   output logic                             q_push,
   output psg_pkg::psg_cmd_type             cmd,
   output logic [DIST_BITS-1:0]             min_front,
   output logic [DIST_BITS-1:0]             min_rear
);
   import psg_pkg::*;

   localparam int CMP_W = (DIST_BITS > CFG_DIST_W) ? DIST_BITS : CFG_DIST_W;

   logic                  fv, rv, have, danger, sentinel, warn_gt;
   logic [DIST_BITS-1:0]  dmin;
   logic [CMP_W-1:0]      dmin_x;
   logic [CFG_DIST_W-1:0] dmin_c;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      min_front = '1;
      min_rear  = '1;
      fv = 1'b0;
      rv = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (sens_dist[FRONT_SEL[i]] != '0) begin
            fv = 1'b1;
            if (sens_dist[FRONT_SEL[i]] < min_front) min_front = sens_dist[FRONT_SEL[i]];
         end
         if (sens_dist[REAR_SEL[i]] != '0) begin
            rv = 1'b1;
            if (sens_dist[REAR_SEL[i]] < min_rear) min_rear = sens_dist[REAR_SEL[i]];
         end
      end
      danger = 1'b0;
      for (int i = 0; i < NUM_SENS; i++) begin
         if (sens_dist[i] != '0 && sens_dist[i] <= DIST_BITS'(SENSOR_THD[i])) danger = 1'b1;
      end
   end

   assign have     = fv || rv;
   assign dmin     = (min_front < min_rear) ? min_front : min_rear;
   assign dmin_x   = CMP_W'(dmin);
   assign dmin_c   = dmin_x[CFG_DIST_W-1:0];
   assign sentinel = (dmin_x == CMP_W'(silence_code)) || (dmin_x == CMP_W'(disabled_code));
   assign warn_gt  = warn_thd > danger_thd;

   always_comb begin
      cmd.act       = ACT_OK;
      cmd.need_div  = 1'b0;
      cmd.raw_scale = warn_gt ? '0 : SCALE_HALF;
      cmd.diff      = dmin_c - danger_thd;
      cmd.den       = warn_thd - danger_thd;
      if (!enable) begin
         cmd.act = ACT_OK;
      end else if (have && sentinel) begin
         cmd.act = ACT_HOLD;
      end else if (danger) begin
         cmd.act = ACT_DANGER;
      end else if (have && dmin_x <= CMP_W'(warn_thd)) begin
         // dmin fits the threshold width here, so diff is exact
         cmd.act      = ACT_WARN;
         cmd.need_div = warn_gt && (dmin_c > danger_thd);
      end
   end

endmodule

// ----- rtl/core/psg_queue.sv -----
module psg_queue #(
   parameter int DIST_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psg_pkg::psg_cmd_type  push_cmd,
   input  logic [DIST_BITS-1:0]  push_min_front,
   input  logic [DIST_BITS-1:0]  push_min_rear,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output psg_pkg::psg_cmd_type  head_cmd,
   output logic [DIST_BITS-1:0]  head_min_front,
   output logic [DIST_BITS-1:0]  head_min_rear
);
   import psg_pkg::*;

   psg_cmd_type          cmd_mem   [2];
   logic [DIST_BITS-1:0] front_mem [2];
   logic [DIST_BITS-1:0] rear_mem  [2];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;

   assign head_cmd       = cmd_mem[rd_ptr_ff];
   assign head_min_front = front_mem[rd_ptr_ff];
   assign head_min_rear  = rear_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff]   <= push_cmd;
         front_mem[wr_ptr_ff] <= push_min_front;
         rear_mem[wr_ptr_ff]  <= push_min_rear;
      end
   end

endmodule

// ----- rtl/core/psg_back.sv -----
module psg_back #(
   parameter int DIST_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  psg_pkg::psg_cmd_type              head_cmd,
   input  logic [DIST_BITS-1:0]              head_min_front,
   input  logic [DIST_BITS-1:0]              head_min_rear,
   input  logic [psg_pkg::SCALE_W-1:0]       min_scale,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [psg_pkg::LEVEL_W-1:0]       rsp_safety_state,
   output logic                              rsp_stop_motors,
   output logic                              rsp_apply_scale,
   output logic [psg_pkg::SCALE_W-1:0]       rsp_speed_scale,
   output logic                              rsp_state_changed,
   output logic [DIST_BITS-1:0]              rsp_min_front,
   output logic [DIST_BITS-1:0]              rsp_min_rear
);
   import psg_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [3:0] DIV_LAST = 4'(SCALE_W - 1);

   logic [1:0]            state_ff, state_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [CFG_DIST_W-1:0] rem_ff, rem_in;
   logic                  bit_ff, bit_in;
   logic [SCALE_W-1:0]    quo_ff, quo_in;
   psg_cmd_type           cmd_ff, cmd_in;
   logic [DIST_BITS-1:0]  mf_ff, mf_in, mr_ff, mr_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  valid_ff, valid_in;
   logic                  load;

   logic [CFG_DIST_W:0]   trial;
   logic                  ge;
   logic [SCALE_W-1:0]    scale_clamped;
   logic [LEVEL_W-1:0]    lvl_next;
   logic                  stop_next, apply_next;
   logic [SCALE_W-1:0]    scale_next;

   // output word registers
   logic [LEVEL_W-1:0]    o_state_ff;
   logic                  o_stop_ff, o_apply_ff, o_changed_ff;
   logic [SCALE_W-1:0]    o_scale_ff;
   logic [DIST_BITS-1:0]  o_mf_ff, o_mr_ff;

   assign trial = {rem_ff, bit_ff};
   assign ge    = trial >= {1'b0, cmd_ff.den};

   always_comb begin
      scale_clamped = quo_ff;
      if (scale_clamped < min_scale) scale_clamped = min_scale;
      if (scale_clamped > SCALE_ONE) scale_clamped = SCALE_ONE;
   end

   always_comb begin
      lvl_next   = LVL_OK;
      stop_next  = 1'b0;
      apply_next = 1'b0;
      scale_next = SCALE_ONE;
      case (cmd_ff.act)
         ACT_HOLD:   lvl_next = level_ff;
         ACT_DANGER: begin
            lvl_next  = LVL_DANGER;
            stop_next = 1'b1;
         end
         ACT_WARN: begin
            lvl_next   = LVL_WARN;
            apply_next = 1'b1;
            scale_next = scale_clamped;
         end
         default:    lvl_next = LVL_OK;
      endcase
   end

   assign load = (state_ff == ST_DONE) && (!valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      quo_in   = quo_ff;
      cmd_in   = cmd_ff;
      mf_in    = mf_ff;
      mr_in    = mr_ff;
      level_in = level_ff;
      valid_in = valid_ff && !rsp_ready;
      q_pop    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = head_cmd;
               mf_in  = head_min_front;
               mr_in  = head_min_rear;
               // quotient of (diff << 8) / den, first partial remainder is diff >> 1
               rem_in = {1'b0, head_cmd.diff[CFG_DIST_W-1:1]};
               bit_in = head_cmd.diff[0];
               cnt_in = '0;
               quo_in = head_cmd.raw_scale;
               state_in = (head_cmd.act == ACT_WARN && head_cmd.need_div) ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            rem_in = ge ? CFG_DIST_W'(trial - {1'b0, cmd_ff.den})
                        : trial[CFG_DIST_W-1:0];
            bit_in = 1'b0;
            quo_in = {quo_ff[SCALE_W-2:0], ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == DIV_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               level_in = lvl_next;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= LVL_OK;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      cmd_ff <= cmd_in;
      mf_ff  <= mf_in;
      mr_ff  <= mr_in;
      if (load) begin
         o_state_ff   <= lvl_next;
         o_stop_ff    <= stop_next;
         o_apply_ff   <= apply_next;
         o_scale_ff   <= scale_next;
         o_changed_ff <= lvl_next != level_ff;
         o_mf_ff      <= mf_ff;
         o_mr_ff      <= mr_ff;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_safety_state  = o_state_ff;
   assign rsp_stop_motors   = o_stop_ff;
   assign rsp_apply_scale   = o_apply_ff;
   assign rsp_speed_scale   = o_scale_ff;
   assign rsp_state_changed = o_changed_ff;
   assign rsp_min_front     = o_mf_ff;
   assign rsp_min_rear      = o_mr_ff;

endmodule

// ----- rtl/core/proximity_speed_guard.sv -----
// Motion safety guard for nine ultrasonic distances. A front stage takes one
// distance word per cycle while its two-entry queue has room, finds the
// nearest front and rear readings and classifies the word (ignore, ok, warn,
// danger). A back stage turns each queued word into one result word; a warn
// word whose speed scale needs the 9-step restoring divider passes through it,
// which sets the sustained rate for warn traffic. Results wait in an output
// register, so the front keeps accepting words while a result is stalled,
// until its queue fills. Register writes are expected only while idle.
module proximity_speed_guard #(
   parameter int DIST_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [DIST_BITS-1:0]             req_dist_rear_left,
   input  logic [DIST_BITS-1:0]             req_dist_rear_center,
   input  logic [DIST_BITS-1:0]             req_dist_rear_right,
   input  logic [DIST_BITS-1:0]             req_dist_front_right,
   input  logic [DIST_BITS-1:0]             req_dist_front_center,
   input  logic [DIST_BITS-1:0]             req_dist_front_left,
   input  logic [DIST_BITS-1:0]             req_dist_head_left,
   input  logic [DIST_BITS-1:0]             req_dist_head_right,
   input  logic [DIST_BITS-1:0]             req_dist_head_center,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [psg_pkg::LEVEL_W-1:0]      rsp_safety_state,
   output logic                             rsp_stop_motors,
   output logic                             rsp_apply_scale,
   output logic [psg_pkg::SCALE_W-1:0]      rsp_speed_scale,
   output logic                             rsp_state_changed,
   output logic [DIST_BITS-1:0]             rsp_min_front,
   output logic [DIST_BITS-1:0]             rsp_min_rear,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [psg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [psg_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [psg_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import psg_pkg::*;

   logic                  enable_ff;
   logic [CFG_DIST_W-1:0] warn_ff, danger_ff, silence_ff, disabled_ff;
   logic [SCALE_W-1:0]    min_scale_ff, min_scale_in;
   logic                  csr_wr;
   logic [2:0]            csr_idx;

   logic [DIST_BITS-1:0]  sens_dist [NUM_SENS];
   logic                  q_full, q_empty, q_push, q_pop;
   psg_cmd_type           push_cmd, head_cmd;
   logic [DIST_BITS-1:0]  push_mf, push_mr, head_mf, head_mr;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      min_scale_in = pwdata[SCALE_W-1:0];
      if (min_scale_in < SCALE_FLOOR_MIN) min_scale_in = SCALE_FLOOR_MIN;
      if (min_scale_in > SCALE_ONE) min_scale_in = SCALE_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         warn_ff      <= 10'd20;
         danger_ff    <= 10'd10;
         min_scale_ff <= SCALE_ONE;
         silence_ff   <= 10'd1023;
         disabled_ff  <= 10'd1022;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ENABLE:   enable_ff    <= pwdata[0];
            REG_WARN:     warn_ff      <= pwdata[CFG_DIST_W-1:0];
            REG_DANGER:   danger_ff    <= pwdata[CFG_DIST_W-1:0];
            REG_MIN_SCL:  min_scale_ff <= min_scale_in;
            REG_SILENCE:  silence_ff   <= pwdata[CFG_DIST_W-1:0];
            REG_DISABLED: disabled_ff  <= pwdata[CFG_DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLE:   prdata = CSR_DATA_W'(enable_ff);
         REG_WARN:     prdata = CSR_DATA_W'(warn_ff);
         REG_DANGER:   prdata = CSR_DATA_W'(danger_ff);
         REG_MIN_SCL:  prdata = CSR_DATA_W'(min_scale_ff);
         REG_SILENCE:  prdata = CSR_DATA_W'(silence_ff);
         REG_DISABLED: prdata = CSR_DATA_W'(disabled_ff);
         default:      prdata = '0;
      endcase
   end

   assign sens_dist[0] = req_dist_rear_left;
   assign sens_dist[1] = req_dist_rear_center;
   assign sens_dist[2] = req_dist_rear_right;
   assign sens_dist[3] = req_dist_front_right;
   assign sens_dist[4] = req_dist_front_center;
   assign sens_dist[5] = req_dist_front_left;
   assign sens_dist[6] = req_dist_head_left;
   assign sens_dist[7] = req_dist_head_right;
   assign sens_dist[8] = req_dist_head_center;

   psg_front #(.DIST_BITS(DIST_BITS)) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .sens_dist     (sens_dist),
      .enable        (enable_ff),
      .warn_thd      (warn_ff),
      .danger_thd    (danger_ff),
      .silence_code  (silence_ff),
      .disabled_code (disabled_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .cmd           (push_cmd),
      .min_front     (push_mf),
      .min_rear      (push_mr)
   );

   psg_queue #(.DIST_BITS(DIST_BITS)) u_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (q_push),
      .push_cmd       (push_cmd),
      .push_min_front (push_mf),
      .push_min_rear  (push_mr),
      .full           (q_full),
      .pop            (q_pop),
      .empty          (q_empty),
      .head_cmd       (head_cmd),
      .head_min_front (head_mf),
      .head_min_rear  (head_mr)
   );

   psg_back #(.DIST_BITS(DIST_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .head_cmd          (head_cmd),
      .head_min_front    (head_mf),
      .head_min_rear     (head_mr),
      .min_scale         (min_scale_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_safety_state  (rsp_safety_state),
      .rsp_stop_motors   (rsp_stop_motors),
      .rsp_apply_scale   (rsp_apply_scale),
      .rsp_speed_scale   (rsp_speed_scale),
      .rsp_state_changed (rsp_state_changed),
      .rsp_min_front     (rsp_min_front),
      .rsp_min_rear      (rsp_min_rear)
   );

   a_stop_is_danger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_motors |-> rsp_safety_state == LVL_DANGER)
      else $error("motor stop without danger state");

   a_idle_scale_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_apply_scale |-> rsp_speed_scale == SCALE_ONE)
      else $error("speed scale not full speed outside warn");

   a_warn_scale_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_apply_scale |->
         rsp_safety_state == LVL_WARN && rsp_speed_scale >= min_scale_ff)
      else $error("warn scale below floor or outside warn state");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import psg_pkg::*;

   localparam int DW = 10;
   localparam int STALL_LIMIT = 4000;
   localparam int unsigned FULL_SPEED = 256;
   localparam int unsigned HALF_SPEED = 128;
   localparam int unsigned SCALE_FLOOR = 13;
   localparam logic [2:0] REG_SPARE = 3'd6;
   localparam logic [2:0] REG_TOP = 3'd7;

   typedef enum int {
      S_REAR_L, S_REAR_C, S_REAR_R, S_FRONT_R, S_FRONT_C, S_FRONT_L,
      S_HEAD_L, S_HEAD_R, S_HEAD_C
   } sensor_type;

   // per-sensor stop distance in cm, same order as sensor_type
   localparam int unsigned STOP_CM [NUM_SENS] = '{20, 15, 20, 15, 10, 15, 20, 20, 20};

   typedef logic [NUM_SENS-1:0][DW-1:0] dist_set_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               stop;
      logic               apply;
      logic [SCALE_W-1:0] scale;
      logic               changed;
      logic [DW-1:0]      min_front;
      logic [DW-1:0]      min_rear;
   } guard_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dist_set_type req_set = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [LEVEL_W-1:0] rsp_safety_state;
   logic rsp_stop_motors;
   logic rsp_apply_scale;
   logic [SCALE_W-1:0] rsp_speed_scale;
   logic rsp_state_changed;
   logic [DW-1:0] rsp_min_front;
   logic [DW-1:0] rsp_min_rear;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // guard settings and level as the block should hold them
   logic               cfg_enable = 1'b1;
   logic [DW-1:0]      cfg_warn = 10'd20;
   logic [DW-1:0]      cfg_danger = 10'd10;
   logic [SCALE_W-1:0] cfg_min_scale = 9'd256;
   logic [DW-1:0]      cfg_silence = 10'd1023;
   logic [DW-1:0]      cfg_disabled = 10'd1022;
   logic [LEVEL_W-1:0] guard_level = LVL_OK;

   dist_set_type  pending_sets [$];
   guard_out_type expected_verdicts [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int sets_sent = 0;
   int results_checked = 0;
   int settings_used = 1;
   int n_warn = 0;
   int n_danger = 0;
   int n_held = 0;
   int quiet_cycles = 0;

   proximity_speed_guard #(.DIST_BITS(DW)) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_dist_rear_left    (req_set[S_REAR_L]),
      .req_dist_rear_center  (req_set[S_REAR_C]),
      .req_dist_rear_right   (req_set[S_REAR_R]),
      .req_dist_front_right  (req_set[S_FRONT_R]),
      .req_dist_front_center (req_set[S_FRONT_C]),
      .req_dist_front_left   (req_set[S_FRONT_L]),
      .req_dist_head_left    (req_set[S_HEAD_L]),
      .req_dist_head_right   (req_set[S_HEAD_R]),
      .req_dist_head_center  (req_set[S_HEAD_C]),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_safety_state      (rsp_safety_state),
      .rsp_stop_motors       (rsp_stop_motors),
      .rsp_apply_scale       (rsp_apply_scale),
      .rsp_speed_scale       (rsp_speed_scale),
      .rsp_state_changed     (rsp_state_changed),
      .rsp_min_front         (rsp_min_front),
      .rsp_min_rear          (rsp_min_rear),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_fail(string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   function automatic string show_verdict(guard_out_type v);
      return $sformatf("state %0d stop %0b apply %0b scale %0d changed %0b front %0d rear %0d",
                       v.level, v.stop, v.apply, v.scale, v.changed, v.min_front, v.min_rear);
   endfunction

   // smallest nonzero reading of three sensors, all ones when none
   function automatic logic [DW-1:0] nearest(dist_set_type s, int a, int b, int c,
                                             output logic found);
      logic [DW-1:0] best;
      int sel [3];
      sel = '{a, b, c};
      best = '1;
      found = 1'b0;
      foreach (sel[k]) begin
         if (s[sel[k]] != 0 && (!found || s[sel[k]] < best)) begin
            best = s[sel[k]];
            found = 1'b1;
         end
      end
      return best;
   endfunction

   function automatic guard_out_type predict_verdict(dist_set_type s);
      guard_out_type o;
      logic [LEVEL_W-1:0] was;
      logic fv, rv, hit;
      logic [DW-1:0] mf, mr, dmin;
      int unsigned scl;
      was = guard_level;
      o = '0;
      o.scale = SCALE_W'(FULL_SPEED);
      mf = nearest(s, S_FRONT_L, S_FRONT_C, S_FRONT_R, fv);
      mr = nearest(s, S_REAR_L, S_REAR_C, S_REAR_R, rv);
      if (!cfg_enable) begin
         guard_level = LVL_OK;
      end else begin
         dmin = '1;
         if (fv) dmin = mf;
         if (rv && (!fv || mr < dmin)) dmin = mr;
         if ((fv || rv) && (dmin == cfg_silence || dmin == cfg_disabled)) begin
            n_held++;  // hold the level, no action
         end else begin
            hit = 1'b0;
            for (int i = 0; i < NUM_SENS; i++) begin
               if (s[i] != 0 && s[i] <= STOP_CM[i]) hit = 1'b1;
            end
            if (hit) begin
               o.stop = 1'b1;
               guard_level = LVL_DANGER;
               n_danger++;
            end else if ((fv || rv) && dmin <= cfg_warn) begin
               if (cfg_warn > cfg_danger) begin
                  scl = (dmin <= cfg_danger) ? 0 :
                        (FULL_SPEED * (32'(dmin) - 32'(cfg_danger))) /
                        (32'(cfg_warn) - 32'(cfg_danger));
               end else begin
                  scl = HALF_SPEED;
               end
               if (scl < 32'(cfg_min_scale)) scl = 32'(cfg_min_scale);
               if (scl > FULL_SPEED) scl = FULL_SPEED;
               o.scale = SCALE_W'(scl);
               o.apply = 1'b1;
               guard_level = LVL_WARN;
               n_warn++;
            end else begin
               guard_level = LVL_OK;
            end
         end
      end
      o.level = guard_level;
      o.changed = (guard_level != was);
      o.min_front = mf;
      o.min_rear = mr;
      return o;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] cfg_value(logic [2:0] idx);
      case (idx)
         REG_ENABLE:   return CSR_DATA_W'(cfg_enable);
         REG_WARN:     return CSR_DATA_W'(cfg_warn);
         REG_DANGER:   return CSR_DATA_W'(cfg_danger);
         REG_MIN_SCL:  return CSR_DATA_W'(cfg_min_scale);
         REG_SILENCE:  return CSR_DATA_W'(cfg_silence);
         REG_DISABLED: return CSR_DATA_W'(cfg_disabled);
         default:      return '0;
      endcase
   endfunction

   // random distance word, mostly around the thresholds now in force
   function automatic dist_set_type make_set();
      dist_set_type s;
      int unsigned kind, r, lo, hi, code;
      kind = $urandom_range(99);
      lo = (cfg_danger > 10) ? 32'(cfg_danger) - 10 : 1;
      hi = (32'(cfg_warn) + 10 > 1023) ? 1023 : 32'(cfg_warn) + 10;
      code = $urandom_range(1) ? 32'(cfg_silence) : 32'(cfg_disabled);
      for (int i = 0; i < NUM_SENS; i++) begin
         r = $urandom_range(99);
         if (kind < 12) begin
            s[i] = DW'($urandom);
         end else if (i >= S_HEAD_L) begin
            s[i] = DW'((r < 8) ? $urandom_range(1, 25) : (r < 25) ? 0 :
                       $urandom_range(21, 1023));
         end else if (kind < 30) begin
            s[i] = '0;
         end else if (kind < 42) begin
            s[i] = DW'((r < 30) ? 0 : $urandom_range(code, 1023));
         end else begin
            s[i] = DW'((r < 6) ? $urandom_range(1, 25) : (r < 20) ? 0 :
                       (r < 75) ? $urandom_range(lo, hi) : $urandom_range(1, 1023));
         end
      end
      // put the sentinel on one front or rear sensor
      if (kind >= 30 && kind < 42) s[$urandom_range(S_FRONT_L)] = DW'(code);
      return s;
   endfunction

   function automatic dist_set_type all_at(int unsigned v);
      dist_set_type s;
      for (int i = 0; i < NUM_SENS; i++) s[i] = DW'(v);
      return s;
   endfunction

   task automatic csr_check(logic [2:0] idx);
      logic [CSR_DATA_W-1:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== cfg_value(idx)) begin
         note_fail($sformatf("register %0d read %0h, expected %0h", idx, got, cfg_value(idx)));
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [CSR_DATA_W-1:0] val);
      int unsigned m;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_ENABLE:   cfg_enable = val[0];
         REG_WARN:     cfg_warn = val[DW-1:0];
         REG_DANGER:   cfg_danger = val[DW-1:0];
         REG_MIN_SCL: begin
            m = 32'(val[SCALE_W-1:0]);
            if (m < SCALE_FLOOR) m = SCALE_FLOOR;
            if (m > FULL_SPEED) m = FULL_SPEED;
            cfg_min_scale = SCALE_W'(m);
         end
         REG_SILENCE:  cfg_silence = val[DW-1:0];
         REG_DISABLED: cfg_disabled = val[DW-1:0];
         default: ;
      endcase
      if (idx <= REG_DISABLED) csr_check(idx);
   endtask

   task automatic set_guard(logic [CSR_DATA_W-1:0] en, warn, danger, mscale, sil, dis);
      csr_write(REG_ENABLE, en);
      csr_write(REG_WARN, warn);
      csr_write(REG_DANGER, danger);
      csr_write(REG_MIN_SCL, mscale);
      csr_write(REG_SILENCE, sil);
      csr_write(REG_DISABLED, dis);
      settings_used++;
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_sets.size() != 0 || req_valid || expected_verdicts.size() != 0);
   endtask

   task automatic run_phase(int n, int s_pct, int r_pct);
      @(negedge clock);
      send_idle_pct = s_pct;
      recv_stall_pct = r_pct;
      repeat (n) pending_sets.push_back(make_set());
      wait_drained();
   endtask

   always @(posedge clock) begin : drive_proc
      logic go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(predict_verdict(req_set));
            sets_sent++;
         end
         if (!req_valid || req_ready) begin
            go = pending_sets.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (go) req_set <= pending_sets.pop_front();
            req_valid <= go;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_proc
      guard_out_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.level = rsp_safety_state;
         got.stop = rsp_stop_motors;
         got.apply = rsp_apply_scale;
         got.scale = rsp_speed_scale;
         got.changed = rsp_state_changed;
         got.min_front = rsp_min_front;
         got.min_rear = rsp_min_rear;
         if (expected_verdicts.size() == 0) begin
            note_fail({"result word with nothing expected: ", show_verdict(got)});
         end else begin
            want = expected_verdicts.pop_front();
            if (got.level !== want.level || got.stop !== want.stop ||
                got.apply !== want.apply || got.scale !== want.scale ||
                got.changed !== want.changed || got.min_front !== want.min_front ||
                got.min_rear !== want.min_rear) begin
               note_fail($sformatf("result %0d expected %s, got %s", results_checked,
                                   show_verdict(want), show_verdict(got)));
            end
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin : stim_proc
      dist_set_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i <= REG_DISABLED; i++) csr_check(3'(i));

      // directed words under the reset settings
      @(negedge clock);
      pending_sets.push_back(all_at(0));
      pending_sets.push_back(all_at(1023));
      pending_sets.push_back(all_at(1022));
      s = all_at(0);
      s[S_FRONT_L] = 10'd1023;
      s[S_HEAD_C] = 10'd5;  // sentinel wins over a head stop
      pending_sets.push_back(s);
      s = all_at(0);
      s[S_HEAD_C] = 10'd5;
      pending_sets.push_back(s);
      for (int i = 0; i < NUM_SENS; i++) begin
         s = all_at(500);
         s[i] = DW'(STOP_CM[i]);
         pending_sets.push_back(s);
      end
      s = all_at(500);
      s[S_FRONT_C] = 10'd11;
      pending_sets.push_back(s);
      pending_sets.push_back(s);
      pending_sets.push_back(all_at(300));
      s = all_at(0);
      s[S_REAR_R] = 10'd21;
      pending_sets.push_back(s);
      s = all_at(1023);
      s[S_REAR_C] = '0;
      pending_sets.push_back(s);
      wait_drained();

      set_guard(1, 100, 40, 0, 1023, 1022);
      run_phase(140, 0, 0);
      set_guard(32'hFFFF_FFFF, 40, 40, 200, 60, 50);
      run_phase(140, 53, 0);
      set_guard(32'hFFFF_FFFE, 20, 10, 256, 1023, 1022);
      run_phase(120, 0, 53);
      set_guard(1, 1023, 0, 13, 0, 1023);
      run_phase(140, 36, 36);
      set_guard(1, 0, 1023, 32'h3FF, 500, 20);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      csr_write(REG_TOP, 32'h0);
      run_phase(140, 0, 0);
      set_guard(1, 300, 25, 100, 30, 600);
      run_phase(150, 53, 53);

      wait_drained();
      repeat (16) @(posedge clock);
      $display("%0d distance words checked over %0d guard settings (%0d results)",
               sets_sent, settings_used, results_checked);
      $display("verdicts seen: %0d warn, %0d danger, %0d held on a sentinel",
               n_warn, n_danger, n_held);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- proximity_speed_guard.f -----
rtl/core/psg_pkg.sv
rtl/core/psg_front.sv
rtl/core/psg_queue.sv
rtl/core/psg_back.sv
rtl/core/proximity_speed_guard.sv
verif/tb.sv
